// ----- rtl/core/gbk_symbol_edit_distance_defines.svh -----
// Assertion macros used by the checker of the edit distance block.
// Every macro expects clk_i and rst_ni in scope.
`ifndef GBK_SYMBOL_EDIT_DISTANCE_DEFINES_SVH
`define GBK_SYMBOL_EDIT_DISTANCE_DEFINES_SVH

// same-cycle implication
`define GSED_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gsed check failed");

// next-cycle implication
`define GSED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gsed check failed");

`endif

// ----- rtl/core/gsed_pkg.sv -----
// Shared types and constants for the GBK symbol edit distance block.
// No dependencies.
package gsed_pkg;

  localparam int unsigned MaxSymbols = 32;
  localparam int unsigned CntW       = $clog2(MaxSymbols + 1);
  localparam int unsigned SymAw      = (MaxSymbols > 1) ? $clog2(MaxSymbols) : 1;
  localparam int unsigned CostW      = CntW;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned SymW       = 2 * ByteW;
  localparam int unsigned DistW      = 6;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QAw        = $clog2(QueueDepth);

  localparam logic [ByteW-1:0] LeadMark = 8'h80;
  localparam logic [CntW-1:0]  MaxCnt   = CntW'(MaxSymbols);
  localparam logic [DistW-1:0] MaxDist  =
      (MaxSymbols > 63) ? {DistW{1'b1}} : DistW'(MaxSymbols);

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_COMPUTE       = 2'd2,
    CMD_CLEAR         = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_PUT_FIRST,
    OP_PUT_SECOND,
    OP_COMPUTE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e             kind;
    logic [SymW-1:0] value;
  } op_t;

  // clamp a cost to the distance port range
  function automatic logic [DistW-1:0] sat_dist(input logic [CostW-1:0] c);
    logic [CostW+DistW-1:0] w;
    w = {{DistW{1'b0}}, c};
    if (w > {{CostW{1'b0}}, {DistW{1'b1}}}) begin
      return {DistW{1'b1}};
    end
    return w[DistW-1:0];
  endfunction

endpackage

// ----- rtl/core/gsed_queue.sv -----
// Short op queue between the command front end and the compute back end.
// Depends on gsed_pkg.
module gsed_queue
  import gsed_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  pop_op_o,
  output logic empty_o
);

  op_t            entries_q [QueueDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   fill_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QAw'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (QAw+1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (QAw+1)'(1);
      end
    end
  end

  assign full_o   = (fill_q == (QAw+1)'(QueueDepth));
  assign empty_o  = (fill_q == '0);
  assign pop_op_o = entries_q[rd_q];

endmodule

// ----- rtl/core/gsed_front.sv -----
// Command front end: takes words, pairs GBK lead bytes with their second byte
// and queues symbol, compute and clear ops. Depends on gsed_pkg.
module gsed_front
  import gsed_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [CmdW-1:0]  command_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output op_t              push_op_o
);

  typedef enum logic {F_IDLE, F_EMIT} state_e;

  state_e           state_q, state_d;
  logic             pf_valid_q, pf_valid_d, ps_valid_q, ps_valid_d;
  logic [ByteW-1:0] pf_lead_q, pf_lead_d, ps_lead_q, ps_lead_d;
  logic             accept;
  cmd_e             cmd;
  logic             sel_valid;
  logic [ByteW-1:0] sel_lead;
  logic             new_valid;
  logic [ByteW-1:0] new_lead;

  assign busy_o = (state_q != F_IDLE) || q_full_i;
  assign accept = start_i && !busy_o;
  assign cmd    = cmd_e'(command_i);

  always_comb begin
    state_d    = state_q;
    pf_valid_d = pf_valid_q;
    pf_lead_d  = pf_lead_q;
    ps_valid_d = ps_valid_q;
    ps_lead_d  = ps_lead_q;
    push_o     = 1'b0;
    push_op_o  = '{kind: OP_CLEAR, value: '0};
    sel_valid  = (cmd == CMD_APPEND_SECOND) ? ps_valid_q : pf_valid_q;
    sel_lead   = (cmd == CMD_APPEND_SECOND) ? ps_lead_q : pf_lead_q;
    new_valid  = sel_valid;
    new_lead   = sel_lead;

    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          unique case (cmd) inside
            CMD_APPEND_FIRST, CMD_APPEND_SECOND: begin
              push_op_o.kind = (cmd == CMD_APPEND_SECOND) ? OP_PUT_SECOND : OP_PUT_FIRST;
              if (sel_valid) begin
                // any byte completes a pending lead
                push_o          = 1'b1;
                push_op_o.value = {sel_lead, data_byte_i};
                new_valid       = 1'b0;
              end else if ((data_byte_i & LeadMark) != '0) begin
                new_valid = 1'b1;
                new_lead  = data_byte_i;
              end else begin
                push_o          = 1'b1;
                push_op_o.value = {{ByteW{1'b0}}, data_byte_i};
              end
              if (cmd == CMD_APPEND_SECOND) begin
                ps_valid_d = new_valid;
                ps_lead_d  = new_lead;
              end else begin
                pf_valid_d = new_valid;
                pf_lead_d  = new_lead;
              end
            end
            CMD_COMPUTE: begin
              state_d = F_EMIT;
            end
            CMD_CLEAR: begin
              push_o         = 1'b1;
              push_op_o.kind = OP_CLEAR;
              pf_valid_d     = 1'b0;
              ps_valid_d     = 1'b0;
            end
          endcase
        end
      end
      F_EMIT: begin
        // flush unfinished leads with low byte zero, then the compute op
        if (!q_full_i) begin
          push_o = 1'b1;
          if (pf_valid_q) begin
            push_op_o  = '{kind: OP_PUT_FIRST, value: {pf_lead_q, {ByteW{1'b0}}}};
            pf_valid_d = 1'b0;
          end else if (ps_valid_q) begin
            push_op_o  = '{kind: OP_PUT_SECOND, value: {ps_lead_q, {ByteW{1'b0}}}};
            ps_valid_d = 1'b0;
          end else begin
            push_op_o.kind = OP_COMPUTE;
            state_d        = F_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      pf_valid_q <= 1'b0;
      ps_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pf_valid_q <= pf_valid_d;
      ps_valid_q <= ps_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pf_lead_q <= pf_lead_d;
    ps_lead_q <= ps_lead_d;
  end

endmodule

// ----- rtl/core/gsed_back.sv -----
// Compute back end: symbol stores, counts, overflow flag and the row-by-row
// dynamic programming walk over the cost row memory. Depends on gsed_pkg.
module gsed_back
  import gsed_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  op_t              op_i,
  output logic             pop_o,
  output logic             valid_o,
  output logic [DistW-1:0] distance_o,
  output logic             overflow_o
);

  typedef enum logic [2:0] {B_IDLE, B_INIT, B_ROW0, B_CELL, B_DONE} state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [CntW-1:0]   i_q, i_d, j_q, j_d, i_prev, j_next;
  logic              ovf_q, ovf_d;
  logic [CostW-1:0]  left_q, left_d, diag_q, diag_d, last_q, last_d;
  logic              valid_q, valid_d, ovf_out_q, ovf_out_d;
  logic [DistW-1:0]  dist_q, dist_d;

  logic [SymW-1:0]   sym1_mem [MaxSymbols];
  logic [SymW-1:0]   sym2_mem [MaxSymbols];
  logic [CostW-1:0]  cost_mem [MaxSymbols+1];
  logic [SymW-1:0]   fs_rd_q, ss_rd_q;
  logic [CostW-1:0]  cost_rd_q;

  logic              s1_we, s2_we, cw_we, fs_re, ss_re, cr_re;
  logic [SymAw-1:0]  s1_waddr, s2_waddr, fs_raddr, ss_raddr;
  logic [CntW-1:0]   cw_addr, cr_raddr;
  logic [CostW-1:0]  cw_data;

  logic [CostW:0]    up_c, left_c, diag_c, best_ab, best;
  logic [CostW-1:0]  new_cell;

  assign pop_o  = (state_q == B_IDLE) && !q_empty_i;
  assign i_prev = i_q - CntW'(1);
  assign j_next = j_q + CntW'(1);

  // one cell: min of above+1, left+1, diag+mismatch
  always_comb begin
    up_c     = {1'b0, cost_rd_q} + (CostW+1)'(1);
    left_c   = {1'b0, left_q} + (CostW+1)'(1);
    diag_c   = {1'b0, diag_q} + ((fs_rd_q != ss_rd_q) ? (CostW+1)'(1) : '0);
    best_ab  = (up_c < left_c) ? up_c : left_c;
    best     = (best_ab < diag_c) ? best_ab : diag_c;
    new_cell = best[CostW-1:0];
  end

  always_comb begin
    state_d   = state_q;
    cnt1_d    = cnt1_q;
    cnt2_d    = cnt2_q;
    i_d       = i_q;
    j_d       = j_q;
    ovf_d     = ovf_q;
    left_d    = left_q;
    diag_d    = diag_q;
    last_d    = last_q;
    valid_d   = 1'b0;
    dist_d    = dist_q;
    ovf_out_d = ovf_out_q;
    s1_we     = 1'b0;
    s2_we     = 1'b0;
    s1_waddr  = cnt1_q[SymAw-1:0];
    s2_waddr  = cnt2_q[SymAw-1:0];
    cw_we     = 1'b0;
    cw_addr   = j_q;
    cw_data   = j_q;
    fs_re     = 1'b0;
    fs_raddr  = i_prev[SymAw-1:0];
    ss_re     = 1'b0;
    ss_raddr  = j_q[SymAw-1:0];
    cr_re     = 1'b0;
    cr_raddr  = j_next;

    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          unique case (op_i.kind)
            OP_PUT_FIRST: begin
              if (cnt1_q < MaxCnt) begin
                s1_we  = 1'b1;
                cnt1_d = cnt1_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_PUT_SECOND: begin
              if (cnt2_q < MaxCnt) begin
                s2_we  = 1'b1;
                cnt2_d = cnt2_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_COMPUTE: begin
              j_d     = '0;
              state_d = B_INIT;
            end
            OP_CLEAR: begin
              cnt1_d = '0;
              cnt2_d = '0;
              ovf_d  = 1'b0;
            end
          endcase
        end
      end
      B_INIT: begin
        // row zero: cost[j] = j
        cw_we = 1'b1;
        if (j_q == cnt2_q) begin
          last_d  = j_q;
          i_d     = CntW'(1);
          state_d = (cnt1_q == '0) ? B_DONE : B_ROW0;
        end else begin
          j_d = j_next;
        end
      end
      B_ROW0: begin
        // old cost[0] is always i-1, so the diagonal needs no read
        fs_re   = 1'b1;
        cw_we   = 1'b1;
        cw_addr = '0;
        cw_data = i_q;
        left_d  = i_q;
        diag_d  = i_prev;
        if (cnt2_q == '0) begin
          last_d = i_q;
          if (i_q == cnt1_q) begin
            state_d = B_DONE;
          end else begin
            i_d = i_q + CntW'(1);
          end
        end else begin
          cr_re    = 1'b1;
          cr_raddr = CntW'(1);
          ss_re    = 1'b1;
          ss_raddr = '0;
          j_d      = CntW'(1);
          state_d  = B_CELL;
        end
      end
      B_CELL: begin
        cw_we   = 1'b1;
        cw_data = new_cell;
        left_d  = new_cell;
        diag_d  = cost_rd_q;
        if (j_q == cnt2_q) begin
          last_d = new_cell;
          if (i_q == cnt1_q) begin
            state_d = B_DONE;
          end else begin
            i_d     = i_q + CntW'(1);
            state_d = B_ROW0;
          end
        end else begin
          cr_re = 1'b1;
          ss_re = 1'b1;
          j_d   = j_next;
        end
      end
      B_DONE: begin
        valid_d   = 1'b1;
        dist_d    = sat_dist(last_q);
        ovf_out_d = ovf_q;
        cnt2_d    = '0;
        state_d   = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt1_q  <= '0;
      cnt2_q  <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt1_q  <= cnt1_d;
      cnt2_q  <= cnt2_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    j_q       <= j_d;
    left_q    <= left_d;
    diag_q    <= diag_d;
    last_q    <= last_d;
    dist_q    <= dist_d;
    ovf_out_q <= ovf_out_d;
  end

  always_ff @(posedge clk_i) begin
    if (s1_we) begin
      sym1_mem[s1_waddr] <= op_i.value;
    end
    if (fs_re) begin
      fs_rd_q <= sym1_mem[fs_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_we) begin
      sym2_mem[s2_waddr] <= op_i.value;
    end
    if (ss_re) begin
      ss_rd_q <= sym2_mem[ss_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_we) begin
      cost_mem[cw_addr] <= cw_data;
    end
    if (cr_re) begin
      cost_rd_q <= cost_mem[cr_raddr];
    end
  end

  assign valid_o    = valid_q;
  assign distance_o = dist_q;
  assign overflow_o = ovf_out_q;

endmodule

// ----- rtl/core/gbk_symbol_edit_distance.sv -----
// Top level of the GBK symbol edit distance block: front end, op queue and
// compute back end. Depends on gsed_pkg, gsed_front, gsed_queue, gsed_back.
//
//   channel   handshake          fields
//   command   start / busy       command_i, data_byte_i
//   result    valid_o (strobe)   distance_o, overflow_o
//
// Append and clear words pass from the front end through the queue to the back end.
// A compute walks the cost row memory row by row, one cell a cycle.
// The front end is busy after a compute while it queues the completion of
// unfinished leads and the compute op, and whenever the four-entry queue is full.
// Reset clears counts, leads, overflow flag and queue; stores need no clearing.
// The result is a one-cycle strobe that the receiver cannot stall.
module gbk_symbol_edit_distance
  import gsed_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [CmdW-1:0]  command_i,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             valid_o,
  output logic [DistW-1:0] distance_o,
  output logic             overflow_o
);

  logic q_full, q_empty, q_push, q_pop;
  op_t  push_op, pop_op;

  gsed_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_op_o   (push_op)
  );

  gsed_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .pop_op_o  (pop_op),
    .empty_o   (q_empty)
  );

  gsed_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .op_i       (pop_op),
    .pop_o      (q_pop),
    .valid_o    (valid_o),
    .distance_o (distance_o),
    .overflow_o (overflow_o)
  );

endmodule

// ----- rtl/core/gsed_checker.sv -----
// Port-level checks for the edit distance block, bound to the top level.
// Depends on gsed_pkg and gbk_symbol_edit_distance_defines.svh.
`include "gbk_symbol_edit_distance_defines.svh"

module gsed_checker
  import gsed_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [CmdW-1:0]  command_i,
  input logic             valid_o,
  input logic [DistW-1:0] distance_o
);

  logic compute_taken;
  assign compute_taken = start && !busy && (cmd_e'(command_i) == CMD_COMPUTE);

  // a result word never repeats in the next cycle
  `GSED_ASSERT_NEXT(a_single_strobe, valid_o, !valid_o)
  // distance is bounded by the word capacity
  `GSED_ASSERT_NOW(a_dist_range, valid_o, distance_o <= MaxDist)
  // compute holds off the next word while it is queued
  `GSED_ASSERT_NEXT(a_busy_after_compute, compute_taken, busy)

endmodule

bind gbk_symbol_edit_distance gsed_checker u_checker (.*);
